>>> rtl/pidm_pkg.sv
// ----------------------------------------------------------------------------
// pidm_pkg
// Types, codes and default sizes shared by the PID controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package pidm_pkg;

	localparam int DATA_WIDTH_DEF     = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int ACC_WIDTH_DEF      = 40;

	localparam int GAIN_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int ACTION_W = 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(100);

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INIT    = 2'd0,
		ACT_ENABLE  = 2'd1,
		ACT_TIEBACK = 2'd2,
		ACT_MANUAL  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_OUT_MIN      = 3'd3,
		REG_OUT_MAX      = 3'd4,
		REG_PERIOD_TICKS = 3'd5,
		REG_REVERSE      = 3'd6,
		REG_MANUAL_VALUE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [PERIOD_W-1:0] period_ticks;
		logic                reverse_acting;
	} cfg_ctl_t;

endpackage

`default_nettype wire

>>> rtl/pidm_if.sv
// ----------------------------------------------------------------------------
// pidm_if
// Valid/ready channels for PID ticks and PID results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidm_in_if
	import pidm_pkg::*;
	#(parameter int DATA_WIDTH = DATA_WIDTH_DEF) ();

	logic                         valid;
	logic                         ready;
	logic [ACTION_W-1:0]          action;
	logic signed [DATA_WIDTH-1:0] process_value;
	logic signed [DATA_WIDTH-1:0] setpoint;

	modport source (output valid, action, process_value, setpoint, input ready);
	modport sink   (input valid, action, process_value, setpoint, output ready);

endinterface

interface pidm_out_if
	import pidm_pkg::*;
	#(parameter int DATA_WIDTH = DATA_WIDTH_DEF) ();

	logic                       valid;
	logic                       ready;
	logic signed [DATA_WIDTH-1:0] control_value;
	logic                       recomputed;
	logic signed [DATA_WIDTH:0] last_error;

	modport source (output valid, control_value, recomputed, last_error, input ready);
	modport sink   (input valid, control_value, recomputed, last_error, output ready);

endinterface

`default_nettype wire

>>> rtl/pidm_regs.sv
// ----------------------------------------------------------------------------
// pidm_regs
// APB register file: gains, clamp limits, period, direction, manual value.
// ----------------------------------------------------------------------------
`default_nettype none

module pidm_regs
	import pidm_pkg::*;
	#(parameter int DATA_WIDTH = DATA_WIDTH_DEF)
	(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [APB_AW-1:0]            paddr,
	input  wire logic [APB_DW-1:0]            pwdata,
	output      logic [APB_DW-1:0]            prdata,
	output      cfg_ctl_t                     cfg,
	output      logic signed [DATA_WIDTH-1:0] out_min,
	output      logic signed [DATA_WIDTH-1:0] out_max,
	output      logic signed [DATA_WIDTH-1:0] manual_value
	);

	localparam logic [DATA_WIDTH-1:0] OUT_MAX_RST = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	cfg_ctl_t              cfg_q;
	logic [DATA_WIDTH-1:0] out_min_q;
	logic [DATA_WIDTH-1:0] out_max_q;
	logic [DATA_WIDTH-1:0] manual_q;
	logic                  wr_en;
	reg_idx_t              idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.period_ticks   <= PERIOD_RST;
			cfg_q.reverse_acting <= 1'b0;
			out_min_q            <= '0;
			out_max_q            <= OUT_MAX_RST;
			manual_q             <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:       cfg_q.gain_p         <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:       cfg_q.gain_i         <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:       cfg_q.gain_d         <= pwdata[GAIN_W-1:0];
				REG_OUT_MIN:      out_min_q            <= pwdata[DATA_WIDTH-1:0];
				REG_OUT_MAX:      out_max_q            <= pwdata[DATA_WIDTH-1:0];
				REG_PERIOD_TICKS: cfg_q.period_ticks   <= pwdata[PERIOD_W-1:0];
				REG_REVERSE:      cfg_q.reverse_acting <= pwdata[0];
				REG_MANUAL_VALUE: manual_q             <= pwdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:       prdata = APB_DW'(cfg_q.gain_p);
			REG_GAIN_I:       prdata = APB_DW'(cfg_q.gain_i);
			REG_GAIN_D:       prdata = APB_DW'(cfg_q.gain_d);
			REG_OUT_MIN:      prdata = APB_DW'(out_min_q);
			REG_OUT_MAX:      prdata = APB_DW'(out_max_q);
			REG_PERIOD_TICKS: prdata = APB_DW'(cfg_q.period_ticks);
			REG_REVERSE:      prdata = APB_DW'(cfg_q.reverse_acting);
			REG_MANUAL_VALUE: prdata = APB_DW'(manual_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg          = cfg_q;
	assign out_min      = $signed(out_min_q);
	assign out_max      = $signed(out_max_q);
	assign manual_value = $signed(manual_q);

endmodule

`default_nettype wire

>>> rtl/pidm_core.sv
// ----------------------------------------------------------------------------
// pidm_core
// Controller state and one-tick update: mode select, period counter, error,
// P/I/D terms, integral saturation and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pidm_core
	import pidm_pkg::*;
	#(
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int ACC_WIDTH      = ACC_WIDTH_DEF
	)
	(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [ACTION_W-1:0]          action,
	input  wire logic signed [DATA_WIDTH-1:0] process_value,
	input  wire logic signed [DATA_WIDTH-1:0] setpoint,
	input  wire cfg_ctl_t                     cfg,
	input  wire logic signed [DATA_WIDTH-1:0] out_min,
	input  wire logic signed [DATA_WIDTH-1:0] out_max,
	input  wire logic signed [DATA_WIDTH-1:0] manual_value,
	output      logic signed [DATA_WIDTH-1:0] control_value,
	output      logic                         recomputed,
	output      logic signed [DATA_WIDTH:0]   last_error
	);

	localparam int EW  = DATA_WIDTH + 1;
	localparam int DFW = EW + 1;
	localparam int PPW = GAIN_W + 1 + EW;
	localparam int DPW = GAIN_W + 1 + DFW;
	localparam int SAW = ((ACC_WIDTH > PPW) ? ACC_WIDTH : PPW) + 1;
	localparam int VW  = ((SAW > DPW) ? SAW : DPW) + 2;

	localparam logic [PPW-1:0] RND_P = PPW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
	localparam logic [DPW-1:0] RND_D = DPW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
	localparam logic signed [SAW-1:0] ACC_MAX = SAW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
	localparam logic signed [SAW-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic [PERIOD_W-1:0]   TICK_MAX = '1;

	logic signed [DATA_WIDTH-1:0] out_q;
	logic signed [ACC_WIDTH-1:0]  acc_q;
	logic signed [EW-1:0]         perr_q;
	logic [PERIOD_W-1:0]          tick_q;

	action_t                  act;
	logic [PERIOD_W-1:0]      tick_inc;
	logic                     recomp;
	logic signed [EW-1:0]     err;
	logic signed [DFW-1:0]    derr;
	logic signed [PPW-1:0]    prod_p, prod_i, term_p, term_i;
	logic signed [DPW-1:0]    prod_d, term_d, d_val;
	logic signed [SAW-1:0]    acc_sum, acc_sat;
	logic signed [ACC_WIDTH-1:0] acc_new;
	logic signed [VW-1:0]     pid_sum, pre_val, clamped;

	logic signed [DATA_WIDTH-1:0] out_d;
	logic signed [ACC_WIDTH-1:0]  acc_d;
	logic signed [EW-1:0]         perr_d;
	logic [PERIOD_W-1:0]          tick_d;

	assign act      = action_t'(action);
	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + PERIOD_W'(1);
	assign recomp   = (act == ACT_ENABLE) && (tick_inc >= cfg.period_ticks);

	assign err  = cfg.reverse_acting ? (EW'(process_value) - EW'(setpoint))
	                                 : (EW'(setpoint) - EW'(process_value));
	assign derr = DFW'(err) - DFW'(perr_q);

	// products, truncated toward zero
	assign prod_p = $signed({1'b0, cfg.gain_p}) * err;
	assign prod_i = $signed({1'b0, cfg.gain_i}) * err;
	assign prod_d = $signed({1'b0, cfg.gain_d}) * derr;
	assign term_p = $signed(prod_p + (prod_p[PPW-1] ? RND_P : '0)) >>> GAIN_FRAC_BITS;
	assign term_i = $signed(prod_i + (prod_i[PPW-1] ? RND_P : '0)) >>> GAIN_FRAC_BITS;
	assign term_d = $signed(prod_d + (prod_d[DPW-1] ? RND_D : '0)) >>> GAIN_FRAC_BITS;

	assign acc_sum = SAW'(acc_q) + SAW'(term_i);
	assign acc_sat = (acc_sum > ACC_MAX) ? ACC_MAX : ((acc_sum < ACC_MIN) ? ACC_MIN : acc_sum);
	assign acc_new = (cfg.gain_i != '0) ? acc_sat[ACC_WIDTH-1:0] : acc_q;
	assign d_val   = (cfg.gain_d != '0) ? term_d : '0;
	assign pid_sum = VW'(term_p) + VW'(acc_new) + VW'(d_val);

	always_comb begin
		out_d  = out_q;
		acc_d  = acc_q;
		perr_d = perr_q;
		tick_d = tick_q;
		case (act)
			ACT_INIT: begin
				pre_val = VW'(out_min);
				acc_d   = '0;
				perr_d  = '0;
				tick_d  = '0;
			end
			ACT_ENABLE: begin
				pre_val = VW'(out_q);
				tick_d  = tick_inc;
				if (recomp) begin
					tick_d = '0;
					perr_d = err;
					if (err != '0) begin
						pre_val = pid_sum;
						acc_d   = acc_new;
					end
				end
			end
			ACT_MANUAL: pre_val = VW'(manual_value);
			ACT_TIEBACK: pre_val = VW'(out_q);
			default: pre_val = VW'(out_q);
		endcase
		if (pre_val < VW'(out_min))
			clamped = VW'(out_min);
		else if (pre_val > VW'(out_max))
			clamped = VW'(out_max);
		else
			clamped = pre_val;
		out_d = clamped[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			acc_q  <= '0;
			perr_q <= '0;
			tick_q <= '0;
		end else if (advance) begin
			out_q  <= out_d;
			acc_q  <= acc_d;
			perr_q <= perr_d;
			tick_q <= tick_d;
		end
	end

	assign control_value = out_d;
	assign recomputed    = recomp;
	assign last_error    = perr_d;

`ifndef SYNTHESIS
	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && act == ACT_INIT) |=> (tick_q == '0 && acc_q == '0 && perr_q == '0))
		else $error("init tick did not clear controller state");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(out_q) && $stable(acc_q) && $stable(tick_q)))
		else $error("controller state changed without an item");

	a_recomp_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && recomp) |=> (tick_q == '0))
		else $error("period counter not restarted after recompute");

	a_error_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !recomp && act != ACT_INIT) |=> $stable(perr_q))
		else $error("stored error changed without recompute");
`endif

endmodule

`default_nettype wire

>>> rtl/pid_controller_with_modes_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_with_modes_unit
// Fixed-point PID controller with init, enable, tieback and manual modes.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid/ready     action, process_value, setpoint
//   out_ch   out  valid/ready     control_value, recomputed, last_error
//   apb      in   psel/penable    gain_p..manual_value at 4*index
//
// One item per cycle while the result side is not stalled; an item passes the input
// register, then the controller update into the result register.
// The controller state updates as the item moves from the input register to
// the result register, so the next item sees the updated state.
// Reset clears the controller state and loads register defaults.
// A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_with_modes_unit
	import pidm_pkg::*;
	#(
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int ACC_WIDTH      = ACC_WIDTH_DEF
	)
	(
	input  wire logic              clk,
	input  wire logic              arst_n,
	pidm_in_if.sink                in_ch,
	pidm_out_if.source             out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready
	);

	cfg_ctl_t                     cfg;
	logic signed [DATA_WIDTH-1:0] out_min, out_max, manual_value;

	logic                         valid_s1;
	logic [ACTION_W-1:0]          action_s1;
	logic signed [DATA_WIDTH-1:0] pv_s1, sp_s1;

	logic                         valid_s2;
	logic signed [DATA_WIDTH-1:0] cv_s2;
	logic                         recomp_s2;
	logic signed [DATA_WIDTH:0]   lerr_s2;

	logic                         advance;
	logic                         in_take;
	logic signed [DATA_WIDTH-1:0] cv_nx;
	logic                         recomp_nx;
	logic signed [DATA_WIDTH:0]   lerr_nx;

	assign pready = 1'b1;

	pidm_regs #(.DATA_WIDTH(DATA_WIDTH)) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.cfg          (cfg),
		.out_min      (out_min),
		.out_max      (out_max),
		.manual_value (manual_value)
	);

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_take      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= in_ch.action;
			pv_s1     <= in_ch.process_value;
			sp_s1     <= in_ch.setpoint;
		end
		if (advance) begin
			cv_s2     <= cv_nx;
			recomp_s2 <= recomp_nx;
			lerr_s2   <= lerr_nx;
		end
	end

	pidm_core #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.ACC_WIDTH      (ACC_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.action        (action_s1),
		.process_value (pv_s1),
		.setpoint      (sp_s1),
		.cfg           (cfg),
		.out_min       (out_min),
		.out_max       (out_max),
		.manual_value  (manual_value),
		.control_value (cv_nx),
		.recomputed    (recomp_nx),
		.last_error    (lerr_nx)
	);

	assign out_ch.valid         = valid_s2;
	assign out_ch.control_value = cv_s2;
	assign out_ch.recomputed    = recomp_s2;
	assign out_ch.last_error    = lerr_s2;

endmodule

`default_nettype wire

>>> verif/pid_controller_with_modes_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_controller_with_modes_unit_test
// Sends PID ticks through the valid/ready channels and writes registers over
// APB. A model of the controller kept in the bench predicts each result, and
// every accepted result is checked field by field in order.
// ----------------------------------------------------------------------------

module pid_controller_with_modes_unit_test;
	import pidm_pkg::*;

	localparam int DW           = DATA_WIDTH_DEF;
	localparam int LIMIT_CYCLES = 200_000;
	localparam int REPORT_CAP   = 100;

	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

	typedef struct {
		logic signed [DW-1:0] control_value;
		logic                 recomputed;
		logic signed [DW:0]   last_error;
	} pid_result_t;

	class pid_tracker;
		bit [GAIN_W-1:0]   kp = '0;
		bit [GAIN_W-1:0]   ki = '0;
		bit [GAIN_W-1:0]   kd = '0;
		bit [PERIOD_W-1:0] period = PERIOD_RST;
		bit                reverse = 1'b0;
		longint            lo = 0;
		longint            hi = (longint'(1) <<< (DW - 1)) - 1;
		longint            manual = 0;
		longint            ctl = 0;
		longint            integ = 0;
		longint            prev_err = 0;
		int unsigned       ticks = 0;
		pid_result_t       due_results[$];
		int unsigned       mismatches = 0;

		function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] v);
			case (idx)
				REG_GAIN_P:       kp = v[GAIN_W-1:0];
				REG_GAIN_I:       ki = v[GAIN_W-1:0];
				REG_GAIN_D:       kd = v[GAIN_W-1:0];
				REG_OUT_MIN:      lo = $signed(v[DW-1:0]);
				REG_OUT_MAX:      hi = $signed(v[DW-1:0]);
				REG_PERIOD_TICKS: period = v[PERIOD_W-1:0];
				REG_REVERSE:      reverse = v[0];
				REG_MANUAL_VALUE: manual = $signed(v[DW-1:0]);
				default: ;
			endcase
		endfunction

		// gain in Q8.8 times value, truncated toward zero
		function longint scale_gain(bit [GAIN_W-1:0] g, longint v);
			longint mag;
			longint q;
			mag = (v < 0) ? -v : v;
			q = (mag * longint'(g)) >>> GAIN_FRAC_BITS_DEF;
			return (v < 0) ? -q : q;
		endfunction

		function void take_tick(action_t act, logic signed [DW-1:0] pv,
				logic signed [DW-1:0] sp);
			longint acc_max;
			longint acc_min;
			longint pv_l;
			longint sp_l;
			longint value;
			longint err;
			longint d;
			longint a;
			logic rec;
			pid_result_t r;
			acc_max = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
			acc_min = -acc_max - 1;
			pv_l = pv;
			sp_l = sp;
			value = ctl;
			rec = 1'b0;
			case (act)
				ACT_INIT: begin
					value = lo;
					integ = 0;
					prev_err = 0;
					ticks = 0;
				end
				ACT_ENABLE: begin
					if (ticks < 32'hFFFF)
						ticks++;
					if (ticks >= period) begin
						ticks = 0;
						rec = 1'b1;
						err = reverse ? (pv_l - sp_l) : (sp_l - pv_l);
						if (err != 0) begin
							d = 0;
							if (ki != 0) begin
								a = integ + scale_gain(ki, err);
								if (a > acc_max)
									a = acc_max;
								if (a < acc_min)
									a = acc_min;
								integ = a;
							end
							if (kd != 0)
								d = scale_gain(kd, err - prev_err);
							value = scale_gain(kp, err) + integ + d;
						end
						prev_err = err;
					end
				end
				ACT_TIEBACK: ;
				ACT_MANUAL: value = manual;
				default: ;
			endcase
			// when the limits cross, values below the lower limit take it and all others take the upper
			if (value < lo)
				value = lo;
			else if (value > hi)
				value = hi;
			ctl = value;
			r.control_value = ctl[DW-1:0];
			r.recomputed = rec;
			r.last_error = prev_err[DW:0];
			due_results.push_back(r);
		endfunction

		function void report(string field, logic signed [63:0] want,
				logic signed [63:0] got);
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(logic signed [DW-1:0] cv, logic rec,
				logic signed [DW:0] le);
			pid_result_t e;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t result with no tick pending: expected none, actual %0d",
						$time, cv);
				return;
			end
			e = due_results.pop_front();
			if (cv !== e.control_value)
				report("control_value", e.control_value, cv);
			if (rec !== e.recomputed)
				report("recomputed", e.recomputed, rec);
			if (le !== e.last_error)
				report("last_error", e.last_error, le);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              hold_flip = 1'b0;
	bit                steady = 1'b0;
	int unsigned       burst_left = 0;
	int unsigned       cycles = 0;
	pid_tracker        tracker;

	pidm_in_if  #(.DATA_WIDTH(DW)) in_ch ();
	pidm_out_if #(.DATA_WIDTH(DW)) out_ch ();

	pid_controller_with_modes_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				tracker.take_tick(action_t'(in_ch.action), in_ch.process_value,
					in_ch.setpoint);
			if (out_ch.valid && out_ch.ready)
				tracker.check_result(out_ch.control_value, out_ch.recomputed,
					out_ch.last_error);
		end
	end

	// result side: stall pattern drawn at random from four modes, plus one long hold
	initial begin : result_sink
		int unsigned rx_tick;
		int unsigned rx_mode;
		int unsigned hold_left;
		logic hold_seen;
		rx_tick = 0;
		rx_mode = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (rx_tick % 128 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_flip != hold_seen) begin
				hold_seen = hold_flip;
				hold_left = 150;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= $urandom_range(0, 1);
					2: out_ch.ready <= (rx_tick % 4 == 0);
					default: out_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic tick(action_t act, logic signed [DW-1:0] pv, logic signed [DW-1:0] sp);
		int unsigned gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.process_value <= pv;
		in_ch.setpoint <= sp;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic set_cfg(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
			logic [GAIN_W-1:0] kd, logic signed [DW-1:0] lo, logic signed [DW-1:0] hi,
			logic [PERIOD_W-1:0] period, logic rev, logic signed [DW-1:0] man);
		drain();
		reg_write(REG_GAIN_P, APB_DW'(kp));
		reg_write(REG_GAIN_I, APB_DW'(ki));
		reg_write(REG_GAIN_D, APB_DW'(kd));
		reg_write(REG_OUT_MIN, APB_DW'($unsigned(lo)));
		reg_write(REG_OUT_MAX, APB_DW'($unsigned(hi)));
		reg_write(REG_PERIOD_TICKS, APB_DW'(period));
		reg_write(REG_REVERSE, APB_DW'(rev));
		reg_write(REG_MANUAL_VALUE, APB_DW'($unsigned(man)));
	endtask

	function automatic logic signed [DW-1:0] pick_val();
		case ($urandom_range(0, 7))
			0: return VMIN;
			1: return VMAX;
			2: return '0;
			default: return DW'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(int unsigned zero_odds);
		if ($urandom_range(0, 99) < zero_odds)
			return '0;
		case ($urandom_range(0, 4))
			0: return '1;
			1: return GAIN_W'(1) << GAIN_FRAC_BITS_DEF;
			2: return GAIN_W'($urandom_range(1, 1024));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int unsigned ph;
		int unsigned n;
		int unsigned r;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic signed [DW-1:0] lo;
		logic signed [DW-1:0] hi;
		logic signed [DW-1:0] t;
		logic signed [DW-1:0] man;
		logic signed [DW-1:0] pv;
		logic signed [DW-1:0] sp;
		logic [PERIOD_W-1:0] period;
		logic rev;
		action_t act;

		tracker = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.action <= ACT_INIT;
		in_ch.process_value <= '0;
		in_ch.setpoint <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults
		tick(ACT_INIT, 16'sd5, -16'sd5);
		tick(ACT_ENABLE, 16'sd100, -16'sd100);
		tick(ACT_TIEBACK, VMAX, VMIN);
		tick(ACT_MANUAL, VMIN, VMAX);

		// unity P gain, half I, quarter D, full range, recompute every tick: largest errors, zero error
		set_cfg(16'h0100, 16'h0080, 16'h0040, VMIN, VMAX, 16'd1, 1'b0, -16'sd1234);
		tick(ACT_INIT, '0, '0);
		tick(ACT_ENABLE, VMIN, VMAX);
		tick(ACT_ENABLE, VMAX, VMIN);
		tick(ACT_ENABLE, 16'sd77, 16'sd77);
		tick(ACT_TIEBACK, '0, 16'sd9);
		tick(ACT_MANUAL, '0, '0);
		tick(ACT_ENABLE, '0, 16'sd5);

		// zero period, reverse acting, max gains, crossed limits
		set_cfg('1, '1, '1, 16'sd100, -16'sd100, '0, 1'b1, -16'sd1234);
		tick(ACT_ENABLE, VMAX, VMIN);
		tick(ACT_ENABLE, VMIN, VMAX);
		tick(ACT_ENABLE, -16'sd1, -16'sd1);
		tick(ACT_MANUAL, '0, '0);
		tick(ACT_INIT, '0, '0);

		// period of three, integral and derivative off, manual above the clamp
		set_cfg(16'h0200, '0, '0, -16'sd50, 16'sd50, 16'd3, 1'b0, VMAX);
		tick(ACT_ENABLE, '0, 16'sd20);
		tick(ACT_ENABLE, '0, 16'sd20);
		tick(ACT_ENABLE, '0, 16'sd20);
		tick(ACT_ENABLE, 16'sd3, '0);
		tick(ACT_MANUAL, '0, '0);
		tick(ACT_TIEBACK, '0, '0);
		tick(ACT_INIT, '0, '0);

		for (ph = 0; ph < 8; ph++) begin
			kp = pick_gain(10);
			ki = pick_gain(40);
			kd = pick_gain(40);
			case ($urandom_range(0, 3))
				0: begin
					lo = VMIN;
					hi = VMAX;
				end
				1: begin
					lo = pick_val();
					hi = pick_val();
				end
				2: begin
					lo = DW'(-int'($urandom_range(0, 2000)));
					hi = DW'($urandom_range(0, 2000));
				end
				default: begin
					lo = pick_val();
					hi = pick_val();
					if (lo > hi) begin
						t = lo;
						lo = hi;
						hi = t;
					end
				end
			endcase
			r = $urandom_range(0, 19);
			if (r < 12)
				period = PERIOD_W'($urandom_range(0, 4));
			else if (r < 17)
				period = PERIOD_W'($urandom_range(5, 20));
			else if (r < 19)
				period = PERIOD_W'($urandom_range(21, 300));
			else
				period = '1;
			rev = $urandom_range(0, 1);
			man = pick_val();
			set_cfg(kp, ki, kd, lo, hi, period, rev, man);

			// long output stall with the input side kept busy
			if (ph == 3) begin
				hold_flip <= ~hold_flip;
				steady = 1'b1;
			end
			for (n = 0; n < 240; n++) begin
				if (ph == 3 && n == 200)
					steady = 1'b0;
				r = $urandom_range(0, 99);
				if (r < 5)
					act = ACT_INIT;
				else if (r < 72)
					act = ACT_ENABLE;
				else if (r < 86)
					act = ACT_TIEBACK;
				else
					act = ACT_MANUAL;
				pv = pick_val();
				if ($urandom_range(0, 3) == 0)
					sp = pv + DW'($urandom_range(0, 6)) - DW'(3);
				else
					sp = pick_val();
				tick(act, pv, sp);
			end
		end

		drain();
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pidm_pkg.sv
rtl/pidm_if.sv
rtl/pidm_regs.sv
rtl/pidm_core.sv
rtl/pid_controller_with_modes_unit.sv
verif/pid_controller_with_modes_unit_test.sv
